### hw/rtl/edsc_pkg.sv
// Shared widths, register codes, payload types and helpers for the epipolar distance score.
`default_nettype none
package edsc_pkg;

    localparam int COORD_W    = 16;
    localparam int ENTRY_W    = 21;
    localparam int ROW_W      = 63;
    localparam int PROD_W     = 37;
    localparam int LINE_W     = 39;
    localparam int MAG_W      = 29;
    localparam int SQ_W       = 59;
    localparam int ROOT_W     = 30;
    localparam int ROOT_STEPS = 30;
    localparam int RES_W      = 55;
    localparam int AR_W       = 54;
    localparam int QUO_W      = 28;
    localparam int DIST_W     = 24;
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 64;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        REG_ROW_0 = 2'd0,
        REG_ROW_1 = 2'd1,
        REG_ROW_2 = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [AR_W-1:0] ar;
        logic [SQ_W-1:0] sq_first;
        logic [SQ_W-1:0] sq_second;
    } front_t;

    typedef struct packed {
        logic [AR_W-1:0]   ar;
        logic [ROOT_W-1:0] n_first;
        logic [ROOT_W-1:0] n_second;
    } root_t;

    typedef struct packed {
        logic             degenerate;
        logic             ovf_first;
        logic             ovf_second;
        logic [QUO_W-1:0] q_first;
        logic [QUO_W-1:0] q_second;
    } quot_t;

    function automatic logic signed [ENTRY_W-1:0] row_entry(input logic [ROW_W-1:0] row,
                                                          input int unsigned col);
        return row[ENTRY_W*col +: ENTRY_W];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/epipolar_distance_score.sv
// Top level of the symmetric epipolar distance scorer with its register port and output buffer.
// The block takes one correspondence per cycle unless its output buffer is full and returns its score
// through the five-stage line and residual datapath, the 31-stage square root that forms both
// normal lengths and the 29-stage divider that forms both distances, plus a sum stage and the
// output register. A two-entry output buffer lets the input side keep transferring while a result
// waits. The three matrix rows are written through the register port at byte addresses 0, 8 and
// 16, and must be written only while no transfer is in flight.
`default_nettype none
module epipolar_distance_score (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [edsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [edsc_pkg::APB_W-1:0]    pwdata,
    output logic [edsc_pkg::APB_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,   // first_x, first_y, second_x, second_y
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,   // distance
    output logic [0:0]                         m_tuser    // degenerate
);
    import edsc_pkg::*;

    logic [ROW_W-1:0] row_0_reg, row_1_reg, row_2_reg;
    reg_idx_t         idx;
    logic             en;

    logic   front_valid, root_valid, quot_valid;
    front_t front_data;
    root_t  root_data;
    quot_t  quot_data;

    logic              fin_valid_reg;
    logic [DIST_W-1:0] fin_dist_reg, fin_dist_next;
    logic              fin_degen_reg;
    logic [QUO_W:0]    qsum;

    logic              out_valid_reg, skid_valid_reg;
    logic [DIST_W-1:0] out_dist_reg, skid_dist_reg;
    logic              out_degen_reg, skid_degen_reg;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign pready = 1'b1;

    always_comb
    begin
        case (idx)
            REG_ROW_0: prdata = {1'b0, row_0_reg};
            REG_ROW_1: prdata = {1'b0, row_1_reg};
            REG_ROW_2: prdata = {1'b0, row_2_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_0_reg <= '0;
            row_1_reg <= '0;
            row_2_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (idx)
                REG_ROW_0: row_0_reg <= pwdata[ROW_W-1:0];
                REG_ROW_1: row_1_reg <= pwdata[ROW_W-1:0];
                REG_ROW_2: row_2_reg <= pwdata[ROW_W-1:0];
                default:   ;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    edsc_lines u_lines (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .first_x   (s_tdata[15:0]),
        .first_y   (s_tdata[31:16]),
        .second_x  (s_tdata[47:32]),
        .second_y  (s_tdata[63:48]),
        .row_0     (row_0_reg),
        .row_1     (row_1_reg),
        .row_2     (row_2_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    edsc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    edsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .in_data   (root_data),
        .out_valid (quot_valid),
        .out_data  (quot_data)
    );

    always_comb
    begin
        qsum = {1'b0, quot_data.q_first} + {1'b0, quot_data.q_second};
        if (quot_data.degenerate || quot_data.ovf_first || quot_data.ovf_second || qsum[QUO_W])
        begin
            fin_dist_next = DIST_MAX;
        end
        else
        begin
            fin_dist_next = qsum[QUO_W-1:4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                fin_valid_reg <= quot_valid;
            end
            if (!out_valid_reg || m_tready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= fin_valid_reg;
                end
            end
            else if (fin_valid_reg && !skid_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_dist_reg  <= fin_dist_next;
            fin_degen_reg <= quot_data.degenerate;
        end
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_dist_reg  <= skid_dist_reg;
                out_degen_reg <= skid_degen_reg;
            end
            else
            begin
                out_dist_reg  <= fin_dist_reg;
                out_degen_reg <= fin_degen_reg;
            end
        end
        else if (!skid_valid_reg)
        begin
            skid_dist_reg  <= fin_dist_reg;
            skid_degen_reg <= fin_degen_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_dist_reg;
    assign m_tuser[0] = out_degen_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Output buffer holds a result while the output register is empty.");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready && fin_valid_reg))
        else $error("Output buffer filled without a stalled output and a finished result.");

    a_degen_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == DIST_MAX))
        else $error("Degenerate result without a saturated distance.");

endmodule
`default_nettype wire

### hw/rtl/edsc_lines.sv
// Front pipeline: epipolar lines, shared residual and squared normal lengths.
`default_nettype none
module edsc_lines (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [edsc_pkg::COORD_W-1:0] first_x,
    input  wire logic signed [edsc_pkg::COORD_W-1:0] first_y,
    input  wire logic signed [edsc_pkg::COORD_W-1:0] second_x,
    input  wire logic signed [edsc_pkg::COORD_W-1:0] second_y,
    input  wire logic [edsc_pkg::ROW_W-1:0]        row_0,
    input  wire logic [edsc_pkg::ROW_W-1:0]        row_1,
    input  wire logic [edsc_pkg::ROW_W-1:0]        row_2,
    output logic                                   out_valid,
    output edsc_pkg::front_t                       out_data
);
    import edsc_pkg::*;

    logic signed [ENTRY_W-1:0] f [3][3];
    logic [4:0] valid_reg;

    logic signed [PROD_W-1:0] a_reg [3], b_reg [3], c_reg [3];
    logic signed [PROD_W-1:0] d_reg [2], e_reg [2], g_reg [2];
    logic signed [PROD_W-1:0] a_next [3], b_next [3], c_next [3];
    logic signed [PROD_W-1:0] d_next [2], e_next [2], g_next [2];
    logic signed [COORD_W-1:0] x1_s1_reg, y1_s1_reg, x1_s2_reg, y1_s2_reg;

    logic signed [LINE_W-1:0] l_reg [3], t_reg [2], l_next [3], t_next [2];

    logic signed [RES_W-1:0] rp_reg [3], rp_next [3];
    logic [MAG_W-1:0] mag_reg [4], mag_next [4];
    logic [LINE_W-1:0] abs_v [4];

    logic signed [RES_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0] sq_reg [4], sq_next [4];

    logic [RES_W-1:0] abs_r;
    front_t out_reg, out_next;

    always_comb
    begin
        f[0][0] = row_entry(row_0, 0);
        f[0][1] = row_entry(row_0, 1);
        f[0][2] = row_entry(row_0, 2);
        f[1][0] = row_entry(row_1, 0);
        f[1][1] = row_entry(row_1, 1);
        f[1][2] = row_entry(row_1, 2);
        f[2][0] = row_entry(row_2, 0);
        f[2][1] = row_entry(row_2, 1);
        f[2][2] = row_entry(row_2, 2);
        for (int j = 0; j < 3; j++)
        begin
            a_next[j] = PROD_W'(f[0][j]) * PROD_W'(second_x);
            b_next[j] = PROD_W'(f[1][j]) * PROD_W'(second_y);
            c_next[j] = PROD_W'(f[2][j]) <<< (COORD_W - 1);
        end
        for (int i = 0; i < 2; i++)
        begin
            d_next[i] = PROD_W'(f[i][0]) * PROD_W'(first_x);
            e_next[i] = PROD_W'(f[i][1]) * PROD_W'(first_y);
            g_next[i] = PROD_W'(f[i][2]) <<< (COORD_W - 1);
        end
        for (int j = 0; j < 3; j++)
        begin
            l_next[j] = LINE_W'(a_reg[j]) + LINE_W'(b_reg[j]) + LINE_W'(c_reg[j]);
        end
        for (int i = 0; i < 2; i++)
        begin
            t_next[i] = LINE_W'(d_reg[i]) + LINE_W'(e_reg[i]) + LINE_W'(g_reg[i]);
        end
        rp_next[0] = RES_W'(l_reg[0]) * RES_W'(x1_s2_reg);
        rp_next[1] = RES_W'(l_reg[1]) * RES_W'(y1_s2_reg);
        rp_next[2] = RES_W'(l_reg[2]) <<< (COORD_W - 1);
        abs_v[0] = l_reg[0][LINE_W-1] ? LINE_W'(-l_reg[0]) : LINE_W'(l_reg[0]);
        abs_v[1] = l_reg[1][LINE_W-1] ? LINE_W'(-l_reg[1]) : LINE_W'(l_reg[1]);
        abs_v[2] = t_reg[0][LINE_W-1] ? LINE_W'(-t_reg[0]) : LINE_W'(t_reg[0]);
        abs_v[3] = t_reg[1][LINE_W-1] ? LINE_W'(-t_reg[1]) : LINE_W'(t_reg[1]);
        for (int k = 0; k < 4; k++)
        begin
            mag_next[k] = abs_v[k][MAG_W+7:8];
            sq_next[k]  = SQ_W'(mag_reg[k]) * SQ_W'(mag_reg[k]);
        end
        r_next = rp_reg[0] + rp_reg[1] + rp_reg[2];
        abs_r = r_reg[RES_W-1] ? RES_W'(-r_reg) : RES_W'(r_reg);
        out_next.ar        = abs_r[AR_W-1:0];
        out_next.sq_first  = sq_reg[0] + sq_reg[1];
        out_next.sq_second = sq_reg[2] + sq_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            g_reg <= g_next;
            x1_s1_reg <= first_x;
            y1_s1_reg <= first_y;
            x1_s2_reg <= x1_s1_reg;
            y1_s2_reg <= y1_s1_reg;
            l_reg <= l_next;
            t_reg <= t_next;
            rp_reg <= rp_next;
            mag_reg <= mag_next;
            r_reg <= r_next;
            sq_reg <= sq_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = out_reg;

endmodule
`default_nettype wire

### hw/rtl/edsc_isqrt.sv
// Pipelined integer square root, one result bit per stage, two lanes side by side.
`default_nettype none
module edsc_isqrt (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire edsc_pkg::front_t in_data,
    output logic                  out_valid,
    output edsc_pkg::root_t       out_data
);
    import edsc_pkg::*;

    logic [ROOT_STEPS:0] valid_reg;
    logic [SQ_W-1:0] rem_reg [ROOT_STEPS+1][2];
    logic [SQ_W-1:0] res_reg [ROOT_STEPS+1][2];
    logic [AR_W-1:0] ar_reg [ROOT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[ROOT_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0][0] <= in_data.sq_first;
            rem_reg[0][1] <= in_data.sq_second;
            res_reg[0][0] <= '0;
            res_reg[0][1] <= '0;
            ar_reg[0]     <= in_data.ar;
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W:0] BIT_V = (SQ_W+1)'(1) << (SQ_W - 1 - 2*k);
        logic [SQ_W:0]   trial [2];
        logic [SQ_W-1:0] rem_next [2];
        logic [SQ_W-1:0] res_next [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = {1'b0, res_reg[k][l]} + BIT_V;
                if ({1'b0, rem_reg[k][l]} >= trial[l])
                begin
                    rem_next[l] = rem_reg[k][l] - trial[l][SQ_W-1:0];
                    res_next[l] = (res_reg[k][l] >> 1) + BIT_V[SQ_W-1:0];
                end
                else
                begin
                    rem_next[l] = rem_reg[k][l];
                    res_next[l] = res_reg[k][l] >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                ar_reg[k+1]  <= ar_reg[k];
            end
        end
    end

    assign out_valid         = valid_reg[ROOT_STEPS];
    assign out_data.ar       = ar_reg[ROOT_STEPS];
    assign out_data.n_first  = res_reg[ROOT_STEPS][0][ROOT_W-1:0];
    assign out_data.n_second = res_reg[ROOT_STEPS][1][ROOT_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/edsc_div.sv
// Pipelined restoring divider that forms both distances, one quotient bit per stage.
`default_nettype none
module edsc_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire edsc_pkg::root_t in_data,
    output logic                 out_valid,
    output edsc_pkg::quot_t      out_data
);
    import edsc_pkg::*;

    localparam int HI_W = AR_W - QUO_W;

    logic [QUO_W:0] valid_reg;
    logic [ROOT_W-1:0] rem_reg [QUO_W+1][2];
    logic [ROOT_W-1:0] n_reg [QUO_W+1][2];
    logic [QUO_W-1:0]  q_reg [QUO_W+1][2];
    logic [QUO_W-1:0]  low_reg [QUO_W+1];
    logic [1:0]        ovf_reg [QUO_W+1];
    logic              degen_reg [QUO_W+1];

    logic [ROOT_W-1:0] hi;
    logic [1:0]        ovf_next;

    always_comb
    begin
        hi = ROOT_W'(in_data.ar[AR_W-1:QUO_W]);
        ovf_next[0] = hi >= in_data.n_first;
        ovf_next[1] = hi >= in_data.n_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0][0] <= ovf_next[0] ? '0 : hi;
            rem_reg[0][1] <= ovf_next[1] ? '0 : hi;
            n_reg[0][0]   <= in_data.n_first;
            n_reg[0][1]   <= in_data.n_second;
            q_reg[0][0]   <= '0;
            q_reg[0][1]   <= '0;
            low_reg[0]    <= in_data.ar[QUO_W-1:0];
            ovf_reg[0]    <= ovf_next;
            degen_reg[0]  <= (in_data.n_first == '0) || (in_data.n_second == '0);
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [ROOT_W:0]   shifted [2];
        logic [ROOT_W:0]   diff [2];
        logic [ROOT_W-1:0] rem_next [2];
        logic [QUO_W-1:0]  q_next [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                shifted[l] = {rem_reg[k][l], low_reg[k][QUO_W-1-k]};
                diff[l]    = shifted[l] - {1'b0, n_reg[k][l]};
                if (shifted[l] >= {1'b0, n_reg[k][l]})
                begin
                    rem_next[l] = diff[l][ROOT_W-1:0];
                    q_next[l]   = {q_reg[k][l][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = shifted[l][ROOT_W-1:0];
                    q_next[l]   = {q_reg[k][l][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]   <= rem_next;
                q_reg[k+1]     <= q_next;
                n_reg[k+1]     <= n_reg[k];
                low_reg[k+1]   <= low_reg[k];
                ovf_reg[k+1]   <= ovf_reg[k];
                degen_reg[k+1] <= degen_reg[k];
            end
        end
    end

    assign out_valid           = valid_reg[QUO_W];
    assign out_data.degenerate = degen_reg[QUO_W];
    assign out_data.ovf_first  = ovf_reg[QUO_W][0];
    assign out_data.ovf_second = ovf_reg[QUO_W][1];
    assign out_data.q_first    = q_reg[QUO_W][0];
    assign out_data.q_second   = q_reg[QUO_W][1];

endmodule
`default_nettype wire

### tb/epipolar_distance_score_checker.sv
// Checker that predicts and compares the scores of the epipolar distance scorer.
`timescale 1ns / 100ps
module epipolar_distance_score_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          mismatches,
    output int          pending
);
    import edsc_pkg::*;

    typedef struct packed {
        logic [23:0] distance;
        logic        degenerate;
    } score_t;

    logic [62:0] f_rows [3];
    score_t      scores_due [$];

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned normal_length(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        ua = (a < 0 ? -a : a) >> 8;
        ub = (b < 0 ? -b : b) >> 8;
        return floor_root(ua * ua + ub * ub);
    endfunction

    function automatic score_t epipolar_score(logic [63:0] pt);
        longint f [3][3];
        longint x1, y1, x2, y2, l1, l2, l3, t1, t2, r;
        longint unsigned n1, n2, ar, total;
        score_t s;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                f[i][j] = longint'($signed(f_rows[i][21*j +: 21]));
        x1 = longint'($signed(pt[15:0]));
        y1 = longint'($signed(pt[31:16]));
        x2 = longint'($signed(pt[47:32]));
        y2 = longint'($signed(pt[63:48]));
        l1 = f[0][0] * x2 + f[1][0] * y2 + f[2][0] * 32768;
        l2 = f[0][1] * x2 + f[1][1] * y2 + f[2][1] * 32768;
        l3 = f[0][2] * x2 + f[1][2] * y2 + f[2][2] * 32768;
        t1 = f[0][0] * x1 + f[0][1] * y1 + f[0][2] * 32768;
        t2 = f[1][0] * x1 + f[1][1] * y1 + f[1][2] * 32768;
        r = l1 * x1 + l2 * y1 + l3 * 32768;
        n1 = normal_length(l1, l2);
        n2 = normal_length(t1, t2);
        if (n1 == 0 || n2 == 0)
        begin
            s.distance = DIST_MAX;
            s.degenerate = 1'b1;
            return s;
        end
        ar = r < 0 ? -r : r;
        total = (ar / n1 + ar / n2) >> 4;
        s.distance = total > 64'hFFFFFF ? DIST_MAX : total[23:0];
        s.degenerate = 1'b0;
        return s;
    endfunction

    assign pending = scores_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_rows[0] <= '0;
            f_rows[1] <= '0;
            f_rows[2] <= '0;
            mismatches <= 0;
            scores_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[4:3] != REG_NONE)
                f_rows[paddr[4:3]] <= pwdata[62:0];
            if (s_tvalid && s_tready)
                scores_due.insert(scores_due.size(), epipolar_score(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (scores_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual distance %h degenerate %b",
                             $time, m_tdata, m_tuser);
                    mismatches <= mismatches + 1;
                end
                else if (scores_due[0] != {m_tdata, m_tuser[0]})
                begin
                    $display("%0t: mismatch, expected distance %h degenerate %b, actual %h %b",
                             $time, scores_due[0].distance, scores_due[0].degenerate,
                             m_tdata, m_tuser);
                    mismatches <= mismatches + 1;
                    void'(scores_due.pop_front());
                end
                else
                    void'(scores_due.pop_front());
            end
        end
    end
endmodule

### tb/testbench.sv
// Top of the testbench: clock, reset, matrix settings, correspondence stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import edsc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    int          mismatches;
    int          pending;
    bit          steady = 1'b0;
    int          stall_hold = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    epipolar_distance_score dut (.*);
    epipolar_distance_score_checker checker_i (.*);

    always @(posedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            stall_hold <= $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
        else
            m_tready <= $urandom_range(0, 99) < 70;
    end

    task automatic write_row(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_point(logic [63:0] pt);
        int r;
        r = $urandom_range(0, 99);
        if (!steady && r >= 60)
        begin
            s_tvalid <= 1'b0;
            repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [20:0] rand_entry(int kind);
        logic [20:0] e;
        e = $urandom;
        case (kind)
            0: return 21'h0FFFFF;
            1: return 21'h100000;
            2: return $signed(e) >>> $urandom_range(0, 20);
            default: return e;
        endcase
    endfunction

    function automatic logic [63:0] rand_row(int kind);
        return {$urandom_range(0, 1) == 1, rand_entry(kind), rand_entry(kind), rand_entry(kind)};
    endfunction

    function automatic logic [15:0] rand_coord();
        logic [15:0] c;
        c = $urandom;
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return $signed(c) >>> $urandom_range(1, 15);
            default: return c;
        endcase
    endfunction

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] ext [4];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        ext = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        for (int i = 0; i < 8; i++)
            send_point({ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[i / 2]});
        drain();
        write_row(REG_ROW_0, {1'b1, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
        write_row(REG_ROW_1, {1'b0, 21'h100000, 21'h100000, 21'h100000});
        write_row(REG_ROW_2, {1'b1, 21'h000001, 21'h100000, 21'h0FFFFF});
        write_row(REG_NONE, '1);
        for (int i = 0; i < 16; i++)
            send_point({ext[i % 4], ext[(i / 4) % 4], ext[(i + 3) % 4], ext[(i + 1) % 4]});
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            steady = (ph == 3);
            write_row(REG_ROW_0, rand_row(ph < 2 ? ph : $urandom_range(2, 3)));
            write_row(REG_ROW_1, rand_row(ph < 2 ? ph : $urandom_range(2, 3)));
            write_row(REG_ROW_2, ph == 7 ? 64'h0 : rand_row($urandom_range(2, 3)));
            if ($urandom_range(0, 3) == 0)
                write_row(REG_NONE, {$urandom, $urandom});
            for (int i = 0; i < 185; i++)
                send_point({rand_coord(), rand_coord(), rand_coord(), rand_coord()});
        end
        steady = 1'b0;
        drain();
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/edsc_pkg.sv
hw/rtl/edsc_lines.sv
hw/rtl/edsc_isqrt.sv
hw/rtl/edsc_div.sv
hw/rtl/epipolar_distance_score.sv
tb/epipolar_distance_score_checker.sv
tb/testbench.sv
